### hw/rtl/spa_pkg.sv
`default_nettype none

package spa_pkg;

    localparam int MAX_TERMS  = 32;
    localparam int IDX_W      = $clog2(MAX_TERMS);
    localparam int CNT_W      = $clog2(MAX_TERMS + 1);
    localparam int COEFF_IN_W = 16;
    localparam int COEFF_W    = 32;
    localparam int POWER_W    = 8;

    localparam logic signed [COEFF_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W-1){1'b1}}};
    localparam logic signed [COEFF_W-1:0] COEFF_MIN = {1'b1, {(COEFF_W-1){1'b0}}};

    // One table entry; the packing matches the result tdata layout.
    typedef struct packed {
        logic [POWER_W-1:0]        power;
        logic signed [COEFF_W-1:0] coeff;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic signed [COEFF_W-1:0] sum;
        logic                      sum_zero;
        logic                      pow_gt;
        logic                      pow_eq;
    } alu_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SCMP,
        ST_INS_CHK,
        ST_INS_RD,
        ST_INS_WR,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_OUT_RD,
        ST_OUT_LD
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/spa_ram.sv
`default_nettype none

module spa_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 40,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/spa_alu.sv
`default_nettype none

module spa_alu (
    input  wire logic signed [spa_pkg::COEFF_W-1:0]    acc_coeff,
    input  wire logic signed [spa_pkg::COEFF_IN_W-1:0] add_coeff,
    input  wire logic        [spa_pkg::POWER_W-1:0]    entry_power,
    input  wire logic        [spa_pkg::POWER_W-1:0]    key_power,
    output spa_pkg::alu_res_t                          res
);

    import spa_pkg::*;

    logic signed [COEFF_W:0] sum_wide;

    always_comb begin
        sum_wide = (COEFF_W+1)'(acc_coeff) + (COEFF_W+1)'(add_coeff);
        // The top two bits disagree only when the 32-bit range was left.
        if (sum_wide[COEFF_W] != sum_wide[COEFF_W-1]) begin
            res.sum = sum_wide[COEFF_W] ? COEFF_MIN : COEFF_MAX;
        end else begin
            res.sum = sum_wide[COEFF_W-1:0];
        end
        res.sum_zero = (res.sum == '0);
        res.pow_gt   = (entry_power > key_power);
        res.pow_eq   = (entry_power == key_power);
    end

endmodule

`default_nettype wire

### hw/rtl/spa_ctrl.sv
`default_nettype none

module spa_ctrl (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [spa_pkg::COEFF_IN_W-1:0] in_coeff,
    input  wire logic        [spa_pkg::POWER_W-1:0]    in_power,
    input  wire logic                                  in_last,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output spa_pkg::entry_t                            out_entry,
    output logic                                       out_last,
    output logic                                       out_overflow,
    output spa_pkg::mem_req_t                          mem_req,
    input  spa_pkg::entry_t                            mem_rdata,
    output logic signed [spa_pkg::COEFF_IN_W-1:0]      key_coeff,
    output logic        [spa_pkg::POWER_W-1:0]         key_power,
    input  spa_pkg::alu_res_t                          alu_res
);

    import spa_pkg::*;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          k_reg, k_next;
    logic                      dropped_reg, dropped_next;
    logic signed [COEFF_IN_W-1:0] coeff_reg, coeff_next;
    logic [POWER_W-1:0]        power_reg, power_next;
    logic                      last_reg, last_next;
    logic                      m_valid_reg, m_valid_next;
    entry_t                    m_entry_reg, m_entry_next;
    logic                      m_last_reg, m_last_next;
    logic                      m_ovf_reg, m_ovf_next;

    logic [CNT_W-1:0]          k_inc, k_dec, idx_inc;
    logic                      finish;
    logic                      out_free;
    logic                      final_term;

    assign k_inc    = k_reg + CNT_W'(1);
    assign k_dec    = k_reg - CNT_W'(1);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign out_free = !m_valid_reg || out_ready;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        k_next       = k_reg;
        dropped_next = dropped_reg;
        coeff_next   = coeff_reg;
        power_next   = power_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !out_ready;
        m_entry_next = m_entry_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;
        finish       = 1'b0;
        final_term   = 1'b0;
        in_ready     = 1'b0;

        mem_req.we    = 1'b0;
        mem_req.waddr = k_reg[IDX_W-1:0];
        mem_req.wdata = mem_rdata;
        mem_req.raddr = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    coeff_next = in_coeff;
                    power_next = in_power;
                    last_next  = in_last;
                    idx_next   = '0;
                    k_next     = '0;
                    // A zero coefficient leaves the table alone.
                    if (in_coeff != '0) begin
                        state_next = ST_SRCH;
                    end else if (in_last) begin
                        state_next = ST_OUT_RD;
                    end
                end
            end
            ST_SRCH: begin
                if (idx_reg >= count_reg) begin
                    state_next = ST_INS_CHK;
                end else begin
                    state_next = ST_SCMP;
                end
            end
            ST_SCMP: begin
                if (alu_res.pow_gt) begin
                    idx_next   = idx_inc;
                    state_next = ST_SRCH;
                end else if (alu_res.pow_eq) begin
                    if (!alu_res.sum_zero) begin
                        mem_req.we          = 1'b1;
                        mem_req.waddr       = idx_reg[IDX_W-1:0];
                        mem_req.wdata.power = power_reg;
                        mem_req.wdata.coeff = alu_res.sum;
                        finish              = 1'b1;
                    end else begin
                        k_next     = idx_reg;
                        state_next = ST_DEL_RD;
                    end
                end else begin
                    state_next = ST_INS_CHK;
                end
            end
            ST_INS_CHK: begin
                if (count_reg >= CNT_W'(MAX_TERMS)) begin
                    dropped_next = 1'b1;
                    finish       = 1'b1;
                end else begin
                    k_next     = count_reg;
                    state_next = ST_INS_RD;
                end
            end
            ST_INS_RD: begin
                if (k_reg > idx_reg) begin
                    mem_req.raddr = k_dec[IDX_W-1:0];
                    state_next    = ST_INS_WR;
                end else begin
                    mem_req.we          = 1'b1;
                    mem_req.waddr       = idx_reg[IDX_W-1:0];
                    mem_req.wdata.power = power_reg;
                    mem_req.wdata.coeff = COEFF_W'(coeff_reg);
                    count_next          = count_reg + CNT_W'(1);
                    finish              = 1'b1;
                end
            end
            ST_INS_WR: begin
                mem_req.we = 1'b1;
                k_next     = k_dec;
                state_next = ST_INS_RD;
            end
            ST_DEL_RD: begin
                if (k_inc < count_reg) begin
                    mem_req.raddr = k_inc[IDX_W-1:0];
                    state_next    = ST_DEL_WR;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                    finish     = 1'b1;
                end
            end
            ST_DEL_WR: begin
                mem_req.we = 1'b1;
                k_next     = k_inc;
                state_next = ST_DEL_RD;
            end
            ST_OUT_RD: begin
                mem_req.raddr = k_reg[IDX_W-1:0];
                state_next    = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                mem_req.raddr = k_reg[IDX_W-1:0];
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ovf_next   = dropped_reg;
                    if (count_reg == '0) begin
                        m_entry_next = '0;
                        final_term   = 1'b1;
                    end else begin
                        m_entry_next = mem_rdata;
                        final_term   = (k_inc == count_reg);
                    end
                    m_last_next = final_term;
                    if (final_term) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        k_next     = k_inc;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish) begin
            k_next     = '0;
            state_next = last_reg ? ST_OUT_RD : ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        k_reg       <= k_next;
        coeff_reg   <= coeff_next;
        power_reg   <= power_next;
        last_reg    <= last_next;
        m_entry_reg <= m_entry_next;
        m_last_reg  <= m_last_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign out_valid    = m_valid_reg;
    assign out_entry    = m_entry_reg;
    assign out_last     = m_last_reg;
    assign out_overflow = m_ovf_reg;
    assign key_coeff    = coeff_reg;
    assign key_power    = power_reg;

endmodule

`default_nettype wire

### hw/rtl/sparse_polynomial_adder_unit.sv
`default_nettype none

// Channel   Dir  Handshake          tdata (low bit up)             tlast       tuser
// s_        in   s_tvalid/s_tready  term_coeff[15:0], power[23:16] term_last   -
// m_        out  m_tvalid/m_tready  out_coeff[31:0], power[39:32]  out_last    out_overflow
//
// An input item with a zero coefficient leaves the table alone; otherwise
// the table is scanned entry by entry and entries are moved to open or
// close a gap, all through the one table memory. A last item then starts
// the readout of the result terms, in order of falling power. s_tready is
// high only while idle; a stalled m_tready holds the readout. Reset (aresetn
// low, synchronous) empties the table and clears the drop flag.

module sparse_polynomial_adder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // term_coeff[15:0], term_power[23:16]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // out_coeff[31:0], out_power[39:32]
    output logic             m_tlast,
    output logic      [0:0]  m_tuser    // out_overflow[0]
);

    import spa_pkg::*;

    mem_req_t                  mem_req;
    entry_t                    mem_rdata;
    entry_t                    out_entry;
    alu_res_t                  alu_res;
    logic signed [COEFF_IN_W-1:0] key_coeff;
    logic [POWER_W-1:0]        key_power;
    logic                      out_overflow;

    spa_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_coeff     (s_tdata[COEFF_IN_W-1:0]),
        .in_power     (s_tdata[COEFF_IN_W+POWER_W-1:COEFF_IN_W]),
        .in_last      (s_tlast),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_entry    (out_entry),
        .out_last     (m_tlast),
        .out_overflow (out_overflow),
        .mem_req      (mem_req),
        .mem_rdata    (mem_rdata),
        .key_coeff    (key_coeff),
        .key_power    (key_power),
        .alu_res      (alu_res)
    );

    spa_alu u_alu (
        .acc_coeff   (mem_rdata.coeff),
        .add_coeff   (key_coeff),
        .entry_power (mem_rdata.power),
        .key_power   (key_power),
        .res         (alu_res)
    );

    spa_ram #(
        .DEPTH (MAX_TERMS),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    assign m_tdata    = out_entry;
    assign m_tuser[0] = out_overflow;

`ifndef SYNTHESIS
    // A result that is not the last one of a readout means the table is
    // still being read out, so no new item may be taken.
    a_busy_in_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("item accepted in the middle of a readout");

    // A nonzero term always starts a table search.
    a_busy_after_term: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tdata[15:0] != 16'd0) |=> !s_tready)
        else $error("ready stayed high after a nonzero term");

    // A result that is offered but not taken stays as it is.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while it waited");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not return the block to idle");
`endif

endmodule

`default_nettype wire
